### rtl/htw_pkg.sv
// ============================================================================
// Hashed timing wheel package
// Shared types, codes and constants of the timer table.
// ============================================================================
package htw_pkg;

    // Input modes.
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_CANCEL = 3'd2;
    localparam logic [2:0] MODE_BUMP   = 3'd3;
    localparam logic [2:0] MODE_LEFT   = 3'd4;
    localparam logic [2:0] MODE_NEXT   = 3'd5;

    // Result kinds.
    localparam logic [2:0] KIND_EXPIRED   = 3'd0;
    localparam logic [2:0] KIND_CANCELLED = 3'd1;
    localparam logic [2:0] KIND_LEFT      = 3'd2;
    localparam logic [2:0] KIND_NEXT      = 3'd3;
    localparam logic [2:0] KIND_NONE      = 3'd4;
    localparam logic [2:0] KIND_BUMPED    = 3'd5;

    localparam int ROUND_W = 24;

    // Input item.
    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  timer_id;
        logic [31:0] amount;
    } t_cmd;

    // Result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  timer_id_res;
        logic [31:0] value;
        logic        last;
    } t_res;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SET,
        ST_LEFT_MUL,
        ST_LEFT_OUT,
        ST_BUMP_SCAN,
        ST_NEXT_SCAN,
        ST_EMIT
    } t_state;

endpackage

### rtl/htw_if.sv
// ============================================================================
// Hashed timing wheel channel
// Valid/ready channel that carries one payload item.
// ============================================================================
interface htw_if #(
    parameter int W = 39
) (
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/htw_front.sv
// ============================================================================
// Hashed timing wheel front end
// Accepts items, drops undefined modes and queues the rest in a short FIFO.
// ============================================================================
module htw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  htw_pkg::t_cmd        i_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output htw_pkg::t_cmd        o_cmd
);
    // Two-entry queue between the front and the back.
    htw_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;
    logic          w_good;

    assign w_good  = i_cmd.mode <= htw_pkg::MODE_NEXT;
    assign o_ready = r_cnt != 2'd2;
    assign w_push  = i_valid && o_ready && w_good;
    assign o_valid = r_cnt != 2'd0;
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### rtl/htw_back.sv
// ============================================================================
// Hashed timing wheel back end
// Holds the timer table and executes one command at a time.
// ============================================================================
module htw_back #(
    parameter int WHEEL_SIZE = 256,
    parameter int NUM_TIMERS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [9:0]    i_interval,
    input  logic          i_valid,
    output logic          o_ready,
    input  htw_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output htw_pkg::t_res o_res
);
    localparam int SW  = $clog2(WHEEL_SIZE);
    localparam int RW  = htw_pkg::ROUND_W;
    localparam int IW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW  = $clog2(NUM_TIMERS + 1);
    localparam int DW  = 32 - SW + 1;

    htw_pkg::t_state r_st, n_st;

    logic [NUM_TIMERS-1:0] r_act;
    logic [SW-1:0]         r_slot [NUM_TIMERS];
    logic [RW-1:0]         r_rnd  [NUM_TIMERS];
    logic [SW-1:0]         r_pos;
    logic [31:0]           r_blog;
    logic [CW-1:0]         r_tot;

    htw_pkg::t_cmd r_cmd;
    // Divider registers: r_quo holds quotient bits, r_rem the partial remainder.
    logic [32:0]   r_quo;
    logic [10:0]   r_rem;
    logic [5:0]    r_cnt;
    logic [9:0]    r_itv;
    // Scan state.
    logic [IW:0]   r_idx;
    logic [SW:0]   r_steps;
    logic [SW-1:0] r_wpos;
    logic [SW-1:0] r_keep;
    logic [DW-1:0] r_c;
    logic [32:0]   r_best;
    logic [63:0]   r_prod;
    htw_pkg::t_res r_out;
    logic          r_ovld;

    logic [9:0]    w_itv;
    assign w_itv = (i_interval == 10'd0) ? 10'd1 : i_interval;

    assign o_valid = r_ovld;
    assign o_res   = r_out;
    assign o_ready = (r_st == htw_pkg::ST_IDLE) && !r_ovld;

    // Entry currently addressed by the scan or the command.
    logic [IW-1:0] w_i;
    logic          w_idok;
    logic [SW-1:0] w_dist;
    logic [32+SW:0] w_t;
    logic [10:0]   w_trial;
    logic [32:0]   w_ticks;
    logic [32:0]   w_rsat;
    logic [DW-1:0] w_cuse;

    always_comb begin
        w_i = (r_st == htw_pkg::ST_BUMP_SCAN || r_st == htw_pkg::ST_NEXT_SCAN)
            ? r_idx[IW-1:0] : IW'(r_cmd.timer_id);
        w_idok  = {28'd0, r_cmd.timer_id} < 32'(NUM_TIMERS);
        w_dist  = r_slot[w_i] - r_pos;
        w_t     = {{(33-RW){1'b0}}, r_rnd[w_i], {SW{1'b0}}} + {{33{1'b0}}, w_dist};
        w_trial = {r_rem[9:0], r_quo[32]} ;
        w_ticks = r_quo + {1'b0, r_blog};
        w_rsat  = w_ticks >> SW;
        w_cuse  = (r_wpos == r_keep) ? r_c - DW'(1) : r_c;
    end

    // Next state of the sequencer.
    always_comb begin
        n_st = r_st;
        case (r_st)
            htw_pkg::ST_IDLE: begin
                if (i_valid && o_ready) begin
                    case (i_cmd.mode)
                        htw_pkg::MODE_ADD: begin
                            n_st = htw_pkg::ST_IDLE;
                        end
                        htw_pkg::MODE_SET: begin
                            n_st = htw_pkg::ST_DIV;
                        end
                        htw_pkg::MODE_CANCEL: begin
                            n_st = htw_pkg::ST_SET;
                        end
                        htw_pkg::MODE_BUMP: begin
                            n_st = (r_tot == '0) ? htw_pkg::ST_EMIT
                                                 : htw_pkg::ST_BUMP_SCAN;
                        end
                        htw_pkg::MODE_LEFT: begin
                            n_st = htw_pkg::ST_LEFT_MUL;
                        end
                        default: begin
                            n_st = htw_pkg::ST_NEXT_SCAN;
                        end
                    endcase
                end
            end
            htw_pkg::ST_DIV: begin
                if (r_cnt == 6'd1) begin
                    n_st = htw_pkg::ST_SET;
                end
            end
            htw_pkg::ST_SET: begin
                n_st = htw_pkg::ST_IDLE;
            end
            htw_pkg::ST_LEFT_MUL: begin
                n_st = htw_pkg::ST_LEFT_OUT;
            end
            htw_pkg::ST_LEFT_OUT: begin
                n_st = htw_pkg::ST_IDLE;
            end
            htw_pkg::ST_BUMP_SCAN: begin
                if (r_steps == '0) begin
                    n_st = htw_pkg::ST_EMIT;
                end
            end
            htw_pkg::ST_NEXT_SCAN: begin
                if (r_idx == (IW+1)'(NUM_TIMERS - 1)) begin
                    n_st = htw_pkg::ST_EMIT;
                end
            end
            htw_pkg::ST_EMIT: begin
                if (!r_ovld || i_ready) begin
                    n_st = htw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_st = htw_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= htw_pkg::ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= '0;
            r_pos  <= '0;
            r_blog <= '0;
            r_tot  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            case (r_st)
                htw_pkg::ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.mode)
                            htw_pkg::MODE_ADD: begin
                                r_blog <= ({1'b0, r_blog} + {1'b0, i_cmd.amount} > 33'hFFFFFFFF)
                                    ? 32'hFFFFFFFF : r_blog + i_cmd.amount;
                            end
                            htw_pkg::MODE_SET: begin
                                // Ceiling division: divide amount + itv - 1.
                                r_quo <= {1'b0, i_cmd.amount} + {23'd0, w_itv} - 33'd1;
                                r_rem <= '0;
                                r_itv <= w_itv;
                                r_cnt <= 6'd33;
                            end
                            htw_pkg::MODE_CANCEL: begin
                            end
                            htw_pkg::MODE_BUMP: begin
                                r_blog  <= '0;
                                r_c     <= DW'(r_blog >> SW) + DW'(1);
                                r_keep  <= r_pos + r_blog[SW-1:0];
                                r_wpos  <= r_pos;
                                r_steps <= ({1'b0, r_blog} > 33'(WHEEL_SIZE))
                                    ? (SW+1)'(WHEEL_SIZE) : r_blog[SW:0];
                                r_idx   <= '0;
                            end
                            htw_pkg::MODE_LEFT: begin
                            end
                            default: begin
                                r_idx  <= '0;
                                r_best <= 33'hFFFFFFFF;
                            end
                        endcase
                    end
                end
                htw_pkg::ST_DIV: begin
                    // One restoring division step per cycle.
                    if (w_trial >= {1'b0, r_itv}) begin
                        r_rem <= w_trial - {1'b0, r_itv};
                        r_quo <= {r_quo[31:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[31:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                end
                htw_pkg::ST_SET: begin
                    if (r_cmd.mode == htw_pkg::MODE_SET) begin
                        if (w_idok && !r_act[w_i]) begin
                            r_slot[w_i] <= w_ticks[SW-1:0] + r_pos;
                            r_rnd[w_i]  <= (w_rsat > 33'(2**RW - 1))
                                ? {RW{1'b1}} : w_rsat[RW-1:0];
                            r_act[w_i]  <= 1'b1;
                            r_tot       <= r_tot + CW'(1);
                        end
                    end else if (w_idok && r_act[w_i]) begin
                        r_act[w_i]  <= 1'b0;
                        r_slot[w_i] <= '0;
                        r_rnd[w_i]  <= '0;
                        r_tot       <= r_tot - CW'(1);
                        r_out  <= '{htw_pkg::KIND_CANCELLED, r_cmd.timer_id, 32'd0, 1'b1};
                        r_ovld <= 1'b1;
                    end
                end
                htw_pkg::ST_LEFT_MUL: begin
                    if (w_idok && r_act[w_i]) begin
                        r_prod <= ((w_t[32:0] < {1'b0, r_blog}) ? 64'd0
                                   : 64'(w_t[32:0] - {1'b0, r_blog})) * 64'(w_itv);
                    end else begin
                        r_prod <= '0;
                    end
                end
                htw_pkg::ST_LEFT_OUT: begin
                    r_out  <= '{htw_pkg::KIND_LEFT, r_cmd.timer_id,
                               (r_prod > 64'hFFFFFFFF) ? 32'hFFFFFFFF : r_prod[31:0], 1'b1};
                    r_ovld <= 1'b1;
                end
                htw_pkg::ST_BUMP_SCAN: begin
                    // One entry per cycle while no result waits to be taken; a slot is done after all entries.
                    if (r_steps == '0) begin
                        r_pos <= r_keep;
                    end else if (!r_ovld || i_ready) begin
                        if (r_act[w_i] && r_slot[w_i] == r_wpos) begin
                            if ({{(33-RW){1'b0}}, r_rnd[w_i]} < 33'(w_cuse)) begin
                                r_act[w_i]  <= 1'b0;
                                r_slot[w_i] <= '0;
                                r_rnd[w_i]  <= '0;
                                r_tot       <= r_tot - CW'(1);
                                r_out  <= '{htw_pkg::KIND_EXPIRED, 4'(w_i), 32'd0, 1'b0};
                                r_ovld <= 1'b1;
                            end else begin
                                r_rnd[w_i] <= r_rnd[w_i] - RW'(w_cuse);
                            end
                        end
                        if (r_idx == (IW+1)'(NUM_TIMERS - 1)) begin
                            r_idx   <= '0;
                            r_c     <= w_cuse;
                            r_wpos  <= r_wpos + SW'(1);
                            r_steps <= r_steps - (SW+1)'(1);
                        end else begin
                            r_idx <= r_idx + (IW+1)'(1);
                        end
                    end
                end
                htw_pkg::ST_NEXT_SCAN: begin
                    if (r_act[w_i] && {1'b0, w_t[31+SW:0]} < {1'b0, r_best}
                        && w_t < (33+SW)'(r_best)) begin
                        r_best <= w_t[32:0];
                    end
                    if (r_idx != (IW+1)'(NUM_TIMERS - 1)) begin
                        r_idx <= r_idx + (IW+1)'(1);
                    end
                end
                htw_pkg::ST_EMIT: begin
                    if (!r_ovld || i_ready) begin
                        if (r_cmd.mode == htw_pkg::MODE_BUMP) begin
                            r_out <= '{htw_pkg::KIND_BUMPED, 4'd0, 32'd0, 1'b1};
                        end else if (r_tot == '0) begin
                            r_out <= '{htw_pkg::KIND_NONE, 4'd0, 32'd0, 1'b1};
                        end else begin
                            r_out <= '{htw_pkg::KIND_NEXT, 4'd0,
                                       (r_best < {1'b0, r_blog}) ? 32'd0
                                       : 32'(r_best - {1'b0, r_blog}), 1'b1};
                        end
                        r_ovld <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

### rtl/hashed_timing_wheel.sv
// Set runs a 33-step divider; the next-timeout query scans every entry; bump walks
// min(backlog, WHEEL_SIZE) slots and visits every entry in each, one entry
// per cycle while no result waits to be taken.
// One item is executed at a time; a two-item queue decouples input.
// Reset is synchronous, active low; all timers turn inactive at once.
// ============================================================================
// Hashed timing wheel
// Timer table on a wheel of slots with set, cancel, bump and queries.
// ============================================================================
module hashed_timing_wheel #(
    parameter int WHEEL_SIZE = 256,
    parameter int NUM_TIMERS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_data,
    htw_if.sink        i_in,
    htw_if.source      o_out
);
    logic [9:0]    r_interval;
    logic          w_qv;
    logic          w_qr;
    htw_pkg::t_cmd w_qc;
    htw_pkg::t_res w_res;

    // Tick interval register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= 10'd1;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_data;
        end
    end

    htw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_cmd   (htw_pkg::t_cmd'(i_in.data)),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_cmd   (w_qc)
    );

    htw_back #(.WHEEL_SIZE(WHEEL_SIZE), .NUM_TIMERS(NUM_TIMERS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_interval (r_interval),
        .i_valid    (w_qv),
        .o_ready    (w_qr),
        .i_cmd      (w_qc),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (w_res)
    );

    assign o_out.data = w_res;

`ifndef SYNTHESIS
    // A shown result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result changed while stalled");
    // The back end takes no command while a result is pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !w_qr)
        else $error("command taken with result pending");
`endif
endmodule

### sim/htw_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Hashed timing wheel checker
// Watches the command and result channels, keeps its own copy of the timer
// table, predicts every result and compares it field by field.
// ============================================================================
module htw_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_data,
    htw_if             i_cmd,
    htw_if             i_res,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int SLOTS  = 256;
    localparam int TIMERS = 16;
    localparam longint unsigned U32_TOP   = 64'hFFFF_FFFF;
    localparam longint unsigned ROUND_TOP = 64'hFF_FFFF;

    // Shadow copy of the timer table.
    logic                        tm_active [TIMERS];
    logic [7:0]                  tm_slot   [TIMERS];
    logic [htw_pkg::ROUND_W-1:0] tm_rounds [TIMERS];
    logic [7:0]                  wheel_pos;
    logic [31:0]                 backlog;
    int                          live_timers;
    logic [9:0]                  interval;

    htw_pkg::t_res expected_q [$];

    function automatic void queue_result(input logic [2:0] kind, input logic [3:0] id,
                                         input logic [31:0] val);
        htw_pkg::t_res r;
        r.kind = kind;
        r.timer_id_res = id;
        r.value = val;
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic void clear_timer(input int id);
        tm_active[id] = 1'b0;
        tm_slot[id] = '0;
        tm_rounds[id] = '0;
        live_timers--;
    endfunction

    // Apply one command to the shadow table and queue what it causes.
    function automatic void apply_command(input htw_pkg::t_cmd c);
        longint unsigned tick_ms, ticks, span, cnt, steps, gap, lft, v, best;
        logic [7:0] keep, p;
        int before_n;
        int id;
        id = int'(c.timer_id);
        before_n = expected_q.size();
        tick_ms = (interval == 0) ? 1 : longint'(interval);
        case (c.mode)
            htw_pkg::MODE_ADD: begin
                span = longint'(backlog) + longint'(c.amount);
                backlog = (span > U32_TOP) ? 32'hFFFF_FFFF : span[31:0];
            end
            htw_pkg::MODE_SET: begin
                if (!tm_active[id]) begin
                    ticks = (longint'(c.amount) + tick_ms - 1) / tick_ms + longint'(backlog);
                    tm_slot[id] = 8'((ticks + longint'(wheel_pos)) % SLOTS);
                    tm_rounds[id] = (ticks / SLOTS > ROUND_TOP)
                                  ? ROUND_TOP[htw_pkg::ROUND_W-1:0] : 24'(ticks / SLOTS);
                    tm_active[id] = 1'b1;
                    live_timers++;
                end
            end
            htw_pkg::MODE_CANCEL: begin
                if (tm_active[id]) begin
                    clear_timer(id);
                    queue_result(htw_pkg::KIND_CANCELLED, c.timer_id, '0);
                end
            end
            htw_pkg::MODE_BUMP: begin
                span = longint'(backlog);
                backlog = '0;
                if (live_timers != 0) begin
                    cnt = span / SLOTS + 1;
                    keep = 8'((longint'(wheel_pos) + span) % SLOTS);
                    steps = (span > SLOTS) ? SLOTS : span;
                    p = wheel_pos;
                    // Walk the slots; from the slot the wheel stops at onward, slots see one round fewer.
                    while (steps > 0) begin
                        if (p == keep) cnt--;
                        for (int i = 0; i < TIMERS; i++) begin
                            if (tm_active[i] && tm_slot[i] == p) begin
                                if (longint'(tm_rounds[i]) < cnt) begin
                                    clear_timer(i);
                                    queue_result(htw_pkg::KIND_EXPIRED, 4'(i), '0);
                                end else begin
                                    tm_rounds[i] = tm_rounds[i] - 24'(cnt);
                                end
                            end
                        end
                        p = p + 8'd1;
                        steps--;
                    end
                    wheel_pos = keep;
                end
                queue_result(htw_pkg::KIND_BUMPED, '0, '0);
            end
            htw_pkg::MODE_LEFT: begin
                v = 0;
                if (tm_active[id]) begin
                    gap = (longint'(tm_slot[id]) + SLOTS - longint'(wheel_pos)) % SLOTS;
                    lft = longint'(tm_rounds[id]) * SLOTS + gap;
                    lft = (lft < longint'(backlog)) ? 0 : lft - longint'(backlog);
                    v = lft * tick_ms;
                    if (v > U32_TOP) v = U32_TOP;
                end
                queue_result(htw_pkg::KIND_LEFT, c.timer_id, v[31:0]);
            end
            htw_pkg::MODE_NEXT: begin
                if (live_timers == 0) begin
                    queue_result(htw_pkg::KIND_NONE, '0, '0);
                end else begin
                    best = U32_TOP;
                    for (int i = 0; i < TIMERS; i++) begin
                        if (tm_active[i]) begin
                            gap = (longint'(tm_slot[i]) + SLOTS - longint'(wheel_pos)) % SLOTS;
                            lft = gap + longint'(tm_rounds[i]) * SLOTS;
                            if (lft < best) best = lft;
                        end
                    end
                    best = (best < longint'(backlog)) ? 0 : best - longint'(backlog);
                    queue_result(htw_pkg::KIND_NEXT, '0, best[31:0]);
                end
            end
            default: begin
                // Undefined modes leave everything alone.
            end
        endcase
        if (expected_q.size() > before_n) expected_q[$].last = 1'b1;
    endfunction

    // Compare results first, then take in the new command of this edge.
    always @(posedge i_clk) begin
        htw_pkg::t_res got;
        htw_pkg::t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < TIMERS; i++) begin
                tm_active[i] = 1'b0;
                tm_slot[i] = '0;
                tm_rounds[i] = '0;
            end
            wheel_pos = '0;
            backlog = '0;
            live_timers = 0;
            interval = 10'd1;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = htw_pkg::t_res'(i_res.data);
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result kind=%0d id=%0d value=%0d last=%0b",
                                 $realtime, got.kind, got.timer_id_res, got.value, got.last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.timer_id_res !== want.timer_id_res ||
                        got.value !== want.value || got.last !== want.last) begin
                        if (o_fail_count < 10)
                            $display({"%0t: mismatch expected kind=%0d id=%0d value=%0d ",
                                      "last=%0b, got kind=%0d id=%0d value=%0d last=%0b"},
                                     $realtime, want.kind, want.timer_id_res, want.value,
                                     want.last, got.kind, got.timer_id_res, got.value,
                                     got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) interval = i_cfg_data;
            if (i_cmd.valid && i_cmd.ready) apply_command(htw_pkg::t_cmd'(i_cmd.data));
        end
        o_pending <= expected_q.size();
    end

endmodule

### sim/hashed_timing_wheel_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Hashed timing wheel testbench
// Drives directed and random timer commands with random gaps on both
// channels, changes the tick interval between phases and gives the verdict.
// ============================================================================
module hashed_timing_wheel_tb;

    localparam int IDLE_WAIT   = 160;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [9:0] cfg_data;
    logic       hold_req;
    logic       burst;
    int         fail_count;
    int         pending;
    int         quiet_cycles;

    htw_if #(.W($bits(htw_pkg::t_cmd))) cmd_ch ();
    htw_if #(.W($bits(htw_pkg::t_res))) res_ch ();

    hashed_timing_wheel DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (cmd_ch),
        .o_out      (res_ch)
    );

    htw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int g;
        bit held;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                g = burst ? 0 : gap_len();
                if (g == 0) begin
                    res_ch.ready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic [2:0] mode, input logic [3:0] id, input logic [31:0] amt);
        htw_pkg::t_cmd c;
        int g;
        c.mode = mode;
        c.timer_id = id;
        c.amount = amt;
        g = burst ? 0 : gap_len();
        if (g > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering items and wait until no expected result is pending.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_interval(input logic [9:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random item; returns 0 when it was an undefined mode.
    function automatic int random_item(output logic [2:0] mode, output logic [3:0] id,
                                       output logic [31:0] amt);
        int k;
        int a;
        k = $urandom_range(0, 99);
        a = $urandom_range(0, 99);
        id = 4'($urandom_range(0, 15));
        amt = '0;
        if (k < 25) begin
            mode = htw_pkg::MODE_SET;
            amt = (a < 80) ? $urandom_range(0, 3000) :
                  (a < 90) ? $urandom_range(0, 300000) : $urandom();
        end else if (k < 45) begin
            mode = htw_pkg::MODE_ADD;
            amt = (a < 85) ? $urandom_range(0, 300) :
                  (a < 95) ? $urandom_range(256, 2000) : $urandom();
        end else if (k < 58) begin
            mode = htw_pkg::MODE_BUMP;
        end else if (k < 70) begin
            mode = htw_pkg::MODE_LEFT;
        end else if (k < 82) begin
            mode = htw_pkg::MODE_NEXT;
        end else if (k < 96) begin
            mode = htw_pkg::MODE_CANCEL;
        end else begin
            mode = 3'($urandom_range(6, 7));
            amt = $urandom();
            return 0;
        end
        if ($urandom_range(0, 9) == 0 && mode != htw_pkg::MODE_SET
            && mode != htw_pkg::MODE_ADD)
            amt = $urandom();
        return 1;
    endfunction

    initial begin
        logic [2:0]  m;
        logic [3:0]  id;
        logic [31:0] amt;
        int          sent;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        hold_req <= 1'b0;
        burst <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, undefined modes, zero timeout, saturation.
        send(htw_pkg::MODE_NEXT, 4'd0, '0);
        send(htw_pkg::MODE_LEFT, 4'd15, '0);
        send(htw_pkg::MODE_BUMP, 4'd0, '0);
        send(htw_pkg::MODE_CANCEL, 4'd3, '0);
        send(3'd6, 4'd15, 32'hFFFF_FFFF);
        send(3'd7, 4'd9, 32'h5A5A_A5A5);
        send(htw_pkg::MODE_SET, 4'd0, '0);
        send(htw_pkg::MODE_SET, 4'd0, 32'd77);
        send(htw_pkg::MODE_LEFT, 4'd0, '0);
        send(htw_pkg::MODE_NEXT, 4'd0, '0);
        send(htw_pkg::MODE_ADD, 4'd0, 32'd5);
        send(htw_pkg::MODE_BUMP, 4'd0, '0);
        send(htw_pkg::MODE_SET, 4'd1, 32'hFFFF_FFFF);
        send(htw_pkg::MODE_ADD, 4'd0, 32'hFFFF_FFFF);
        send(htw_pkg::MODE_ADD, 4'd0, 32'd1);
        send(htw_pkg::MODE_SET, 4'd2, 32'hFFFF_FFFF);
        send(htw_pkg::MODE_LEFT, 4'd2, '0);
        send(htw_pkg::MODE_NEXT, 4'd0, '0);
        send(htw_pkg::MODE_BUMP, 4'd0, '0);
        send(htw_pkg::MODE_CANCEL, 4'd1, '0);
        send(htw_pkg::MODE_CANCEL, 4'd2, '0);
        drain();

        // Largest interval with rounding up, then a zero interval.
        set_interval(10'd1023);
        send(htw_pkg::MODE_SET, 4'd5, 32'd1024);
        send(htw_pkg::MODE_LEFT, 4'd5, '0);
        drain();
        set_interval(10'd0);
        send(htw_pkg::MODE_SET, 4'd6, 32'd300);
        send(htw_pkg::MODE_LEFT, 4'd6, '0);
        drain();

        // Random phases with a new interval each time.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_interval(10'd1);
                1: set_interval(10'd1000);
                2: set_interval(10'($urandom_range(1, 1023)));
                3: set_interval(10'd0);
                default: set_interval(10'($urandom()));
            endcase
            burst <= (ph == 3);
            if (ph == 1) begin
                // Receiver holds off while the sender keeps pushing queries.
                hold_req <= 1'b1;
                for (int i = 0; i < 20; i++) send(htw_pkg::MODE_NEXT, 4'd0, '0);
            end
            sent = 0;
            while (sent < 40) begin
                if (random_item(m, id, amt) != 0) sent++;
                send(m, id, amt);
            end
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
